// ===== hdl/asct_pkg.sv =====
// shared types and constants for the audio source selector with clock trim
package asct_pkg;

    typedef enum logic [1:0] {
        SRC_OFF  = 2'd0,
        SRC_USB  = 2'd1,
        SRC_BT   = 2'd2,
        SRC_WLAN = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_EVAL = 2'd0,
        OP_USB  = 2'd1,
        OP_BT   = 2'd2,
        OP_WIFI = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MUTE_KEEP = 2'd0,
        MUTE_ON   = 2'd1,
        MUTE_OFF  = 2'd2
    } t_mute;

    typedef enum logic [1:0] {
        STREAM_NONE    = 2'd0,
        STREAM_RESTART = 2'd1,
        STREAM_BLOCKED = 2'd2
    } t_stream;

    typedef struct packed {
        logic load_quot;
        logic load_rem;
    } t_fmod_en;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STANDBY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USB_READY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BT_READY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIFI_READY   = 3'd4;

    localparam logic [15:0] SWITCH_DELAY_RST = 16'd250;
    localparam logic [31:0] STANDBY_RST      = 32'd600000;

    localparam logic [8:0] PLL_N_MIN     = 9'd341;
    localparam logic [8:0] PLL_N_DOWN    = 9'd342;
    localparam logic [8:0] PLL_N_NOMINAL = 9'd343;
    localparam logic [8:0] PLL_N_UP      = 9'd344;
    localparam logic [8:0] PLL_N_MAX     = 9'd345;

    localparam logic signed [7:0] DRIFT_DEAD = 8'sd25;
    localparam logic signed [7:0] DRIFT_WIDE = 8'sd100;

endpackage

// ===== hdl/asct_floor_mod.sv =====
// two-stage floor remainder of a signed 32-bit value by the frame period
module asct_floor_mod
    import asct_pkg::*;
#(
    parameter int unsigned FRAME_PERIOD = 12288,
    localparam int unsigned FP_W = $clog2(FRAME_PERIOD + 1)
) (
    input  logic            i_clk,
    input  t_fmod_en        i_en,
    input  logic [31:0]     i_value,
    output logic [FP_W-1:0] o_rem
);

    localparam int unsigned RW = FP_W + 1;
    localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / FRAME_PERIOD;
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];
    localparam logic [RW-1:0] OFS_MOD = RW'(64'h8000_0000 % FRAME_PERIOD);
    localparam logic [RW-1:0] FP_R = RW'(FRAME_PERIOD);

    logic [31:0]     n_u;
    logic [63:0]     n_prod;
    logic [31:0]     r_u;
    logic [31:0]     r_quot;
    logic [RW-1:0]   qfp_lo;
    logic [RW-1:0]   rem_raw;
    logic [RW-1:0]   rem_fix;
    logic [RW-1:0]   rem_ofs;
    logic [FP_W-1:0] r_rem;

    // offset to unsigned, estimate quotient by reciprocal (may be one short)
    assign n_u    = i_value ^ 32'h8000_0000;
    assign n_prod = n_u * RECIP;

    always_ff @(posedge i_clk) begin
        if (i_en.load_quot) begin
            r_u    <= n_u;
            r_quot <= n_prod[63:32];
        end
    end

    always_comb begin
        qfp_lo  = r_quot[RW-1:0] * FP_R;
        rem_raw = r_u[RW-1:0] - qfp_lo;
        rem_fix = (rem_raw >= FP_R) ? (rem_raw - FP_R) : rem_raw;
        // undo the offset of 2^31
        if (rem_fix < OFS_MOD) begin
            rem_ofs = rem_fix + FP_R - OFS_MOD;
        end else begin
            rem_ofs = rem_fix - OFS_MOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_rem) begin
            r_rem <= rem_ofs[FP_W-1:0];
        end
    end

    assign o_rem = r_rem;

endmodule

// ===== hdl/audio_source_selector_clock_trim.sv =====
// audio source selector with usb drift tracking and pll trim, top level
//
// input channel: i_valid / o_stall with opcode, time stamp and timer capture.
// an item is taken at a clock edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall with one result item per input item.
// configuration: i_cfg_valid / o_cfg_ready, register index and data; ready is
// always high, so every write is taken at once.
// stages: four (input register, reciprocal multiply, remainder correction,
// state update), in that order; the update stage loads the output register.
// throughput: one item per cycle while the receiver does not stall; the
// capture history is kept in the first stage and all other state in the
// update stage, so items of any kind follow each other directly.
// receiver stall: the output register holds its item and the stages behind it
// fill up; o_stall rises only when every stage holds an item.
// reset (synchronous, active low): mode none, all seen times and the drift
// cleared, trim record zero, power off, registers at their defaults.
module audio_source_selector_clock_trim
    import asct_pkg::*;
#(
    parameter int unsigned TIME_BITS    = 40,
    parameter int unsigned FRAME_PERIOD = 12288
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [TIME_BITS-1:0]        i_now_ms,
    input  logic signed [31:0]          i_counter_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_mode,
    output logic                        o_mode_committed,
    output logic [1:0]                  o_mute_action,
    output logic [1:0]                  o_stream_action,
    output logic                        o_pll_write,
    output logic [8:0]                  o_pll_n,
    output logic                        o_power_enable,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);

    localparam int unsigned FP_W    = $clog2(FRAME_PERIOD + 1);
    localparam int unsigned DRIFT_W = FP_W + 1;
    localparam int unsigned XW      = FP_W + 3;
    localparam int unsigned SUM_W   = (TIME_BITS < 64) ? TIME_BITS + 1 : 64;
    localparam int unsigned CMP_W   = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam logic signed [XW-1:0] FP_X      = XW'(FRAME_PERIOD);
    localparam logic signed [XW-1:0] FP2_X     = XW'(2 * FRAME_PERIOD);
    localparam logic signed [XW-1:0] WRAP_MOD  = XW'(64'h1_0000_0000 % FRAME_PERIOD);
    localparam logic [DRIFT_W-1:0]   FP_D      = DRIFT_W'(FRAME_PERIOD);

    // configuration
    logic [15:0] r_switch_delay;
    logic [31:0] r_standby;
    logic        r_usb_ready;
    logic        r_bt_ready;
    logic        r_wifi_ready;

    // pipeline control
    logic out_free, s3_free, s2_free, s1_free;
    logic s3_go, s1_go, in_acc;
    logic r1_valid, r2_valid, r3_valid, r_out_valid;

    // pipeline payload
    t_op                  r1_op, r2_op, r3_op;
    logic [TIME_BITS-1:0] r1_now, r2_now, r3_now;
    logic [31:0]          r1_cap;
    logic [31:0]          r2_a32, r3_a32;
    logic [31:0]          r_cap_prev;
    logic                 borrow;
    logic [31:0]          a32;
    t_fmod_en             fmod_en;
    logic [FP_W-1:0]      frac_a;

    // block state
    t_mode                r_mode;
    t_mode                r_committed_last;
    logic [TIME_BITS-1:0] r_usb_seen, r_bt_seen, r_wifi_seen;
    logic [DRIFT_W-1:0]   r_drift;
    logic [8:0]           r_trim_written;
    logic                 r_power;

    t_mode                n_mode;
    t_mode                n_committed_last;
    logic [DRIFT_W-1:0]   n_drift;
    logic [8:0]           n_trim_written;
    logic                 n_power;
    logic                 n_committed;
    t_mute                n_mute;
    t_stream              n_stream;
    logic                 n_pll_write;
    logic [8:0]           n_pll_n;

    // output register
    t_mode                r_out_mode;
    logic                 r_out_committed;
    t_mute                r_out_mute;
    t_stream              r_out_stream;
    logic                 r_out_pll_write;
    logic [8:0]           r_out_pll_n;
    logic                 r_out_power;

    // age and mode selection signals
    logic [TIME_BITS-1:0] age_usb, age_bt, age_wifi;
    logic [SUM_W-1:0]     au_s, ab_s, aw_s, dly_s;
    logic                 all_idle;
    t_mode                mode_sel;
    logic                 sel_ready;

    // drift signals
    logic signed [32:0]   v33;
    logic                 wrap_hi, wrap_lo;
    logic signed [XW-1:0] x_raw, x_red;
    logic [FP_W-1:0]      frac_sum;
    logic [8:0]           trim_target;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_delay <= SWITCH_DELAY_RST;
            r_standby      <= STANDBY_RST;
            r_usb_ready    <= 1'b0;
            r_bt_ready     <= 1'b0;
            r_wifi_ready   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SWITCH_DELAY: r_switch_delay <= i_cfg_data[15:0];
                CFG_STANDBY:      r_standby      <= i_cfg_data;
                CFG_USB_READY:    r_usb_ready    <= i_cfg_data[0];
                CFG_BT_READY:     r_bt_ready     <= i_cfg_data[0];
                CFG_WIFI_READY:   r_wifi_ready   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign s3_free  = !r3_valid || out_free;
    assign s2_free  = !r2_valid || s3_free;
    assign s1_free  = !r1_valid || s2_free;
    assign s3_go    = r3_valid && out_free;
    assign s1_go    = r1_valid && s2_free;
    assign in_acc   = i_valid && s1_free;
    assign o_stall  = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r1_valid <= i_valid;
            end
            if (s2_free) begin
                r2_valid <= r1_valid;
            end
            if (s3_free) begin
                r3_valid <= r2_valid;
            end
            if (out_free) begin
                r_out_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_op  <= t_op'(i_opcode);
            r1_now <= i_now_ms;
            r1_cap <= i_counter_value;
        end
        if (s2_free) begin
            r2_op  <= r1_op;
            r2_now <= r1_now;
            r2_a32 <= a32;
        end
        if (s3_free) begin
            r3_op  <= r2_op;
            r3_now <= r2_now;
            r3_a32 <= r2_a32;
        end
    end

    // capture difference less one frame, with the wrap step
    assign borrow = $signed(r_cap_prev) > $signed(r1_cap);
    assign a32    = r1_cap - r_cap_prev - 32'(FRAME_PERIOD) - {31'b0, borrow};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_prev <= '0;
        end else if (s1_go && r1_op == OP_USB) begin
            r_cap_prev <= r1_cap;
        end
    end

    assign fmod_en.load_quot = s2_free;
    assign fmod_en.load_rem  = s3_free;

    asct_floor_mod #(
        .FRAME_PERIOD (FRAME_PERIOD)
    ) u_floor_mod (
        .i_clk   (i_clk),
        .i_en    (fmod_en),
        .i_value (a32),
        .o_rem   (frac_a)
    );

    // ages and source selection
    always_comb begin
        age_usb  = r3_now - r_usb_seen;
        age_bt   = r3_now - r_bt_seen;
        age_wifi = r3_now - r_wifi_seen;
        au_s     = SUM_W'(age_usb);
        ab_s     = SUM_W'(age_bt);
        aw_s     = SUM_W'(age_wifi);
        dly_s    = SUM_W'(r_switch_delay);
        all_idle = (CMP_W'(age_usb) > CMP_W'(r_standby))
                && (CMP_W'(age_bt) > CMP_W'(r_standby))
                && (CMP_W'(age_wifi) > CMP_W'(r_standby));
        mode_sel = r_mode;
        unique case (r_mode)
            SRC_OFF: begin
                if (ab_s < dly_s) mode_sel = SRC_BT;
                else if (au_s < dly_s) mode_sel = SRC_USB;
                else if (aw_s < dly_s) mode_sel = SRC_WLAN;
            end
            SRC_BT: begin
                if (ab_s > au_s + dly_s) mode_sel = SRC_USB;
                else if (ab_s > aw_s + dly_s) mode_sel = SRC_WLAN;
                else if (ab_s > dly_s) mode_sel = SRC_OFF;
            end
            SRC_USB: begin
                if (ab_s < dly_s) mode_sel = SRC_BT;
                else if (au_s > aw_s + dly_s) mode_sel = SRC_WLAN;
                else if (au_s > dly_s) mode_sel = SRC_OFF;
            end
            SRC_WLAN: begin
                if (au_s < dly_s) mode_sel = SRC_USB;
                else if (ab_s < dly_s) mode_sel = SRC_BT;
                else if (aw_s > dly_s) mode_sel = SRC_OFF;
            end
            default: mode_sel = r_mode;
        endcase
        case (mode_sel)
            SRC_USB:  sel_ready = r_usb_ready;
            SRC_BT:   sel_ready = r_bt_ready;
            SRC_WLAN: sel_ready = r_wifi_ready;
            default:  sel_ready = 1'b0;
        endcase
    end

    // new drift: truncated remainder of the wrapped sum, and the pll trim target from it
    always_comb begin
        v33     = $signed({r3_a32[31], r3_a32})
                + $signed({{(33 - DRIFT_W){r_drift[DRIFT_W-1]}}, r_drift});
        wrap_hi = (v33[32:31] == 2'b01);
        wrap_lo = (v33[32:31] == 2'b10);
        x_raw   = $signed({3'b000, frac_a})
                + $signed({{(XW - DRIFT_W){r_drift[DRIFT_W-1]}}, r_drift});
        if (wrap_hi) begin
            x_raw = x_raw - WRAP_MOD;
        end else if (wrap_lo) begin
            x_raw = x_raw + WRAP_MOD;
        end
        if (x_raw < -FP_X) begin
            x_red = x_raw + FP2_X;
        end else if (x_raw < 0) begin
            x_red = x_raw + FP_X;
        end else if (x_raw >= FP2_X) begin
            x_red = x_raw - FP2_X;
        end else if (x_raw >= FP_X) begin
            x_red = x_raw - FP_X;
        end else begin
            x_red = x_raw;
        end
        frac_sum = x_red[FP_W-1:0];
        if (v33[31] && frac_sum != '0) begin
            n_drift = {1'b0, frac_sum} - FP_D;
        end else begin
            n_drift = {1'b0, frac_sum};
        end
        if ($signed(n_drift) < DRIFT_DEAD && $signed(n_drift) > -DRIFT_DEAD) begin
            trim_target = PLL_N_NOMINAL;
        end else if ($signed(n_drift) > DRIFT_WIDE) begin
            trim_target = PLL_N_MIN;
        end else if ($signed(n_drift) > 0) begin
            trim_target = PLL_N_DOWN;
        end else if ($signed(n_drift) < -DRIFT_WIDE) begin
            trim_target = PLL_N_MAX;
        end else begin
            trim_target = PLL_N_UP;
        end
    end

    // item result and next state
    always_comb begin
        n_mode           = r_mode;
        n_committed_last = r_committed_last;
        n_trim_written   = r_trim_written;
        n_power          = r_power;
        n_committed      = 1'b0;
        n_mute           = MUTE_KEEP;
        n_stream         = STREAM_NONE;
        n_pll_write      = 1'b0;
        n_pll_n          = '0;
        case (r3_op)
            OP_EVAL: begin
                n_mode = mode_sel;
                if (mode_sel != r_committed_last) begin
                    if (mode_sel == SRC_OFF) begin
                        n_mute           = MUTE_ON;
                        n_committed      = 1'b1;
                        n_committed_last = mode_sel;
                    end else if (!sel_ready) begin
                        n_stream = STREAM_BLOCKED;
                    end else begin
                        n_pll_write      = 1'b1;
                        n_pll_n          = PLL_N_NOMINAL;
                        n_stream         = STREAM_RESTART;
                        n_mute           = MUTE_OFF;
                        n_committed      = 1'b1;
                        n_committed_last = mode_sel;
                    end
                end
                if (n_stream != STREAM_BLOCKED) begin
                    n_power = !all_idle;
                end
            end
            OP_USB: begin
                if (r_mode == SRC_USB && trim_target != r_trim_written) begin
                    n_trim_written = trim_target;
                    n_pll_write    = 1'b1;
                    n_pll_n        = trim_target;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= SRC_OFF;
            r_committed_last <= SRC_OFF;
            r_usb_seen       <= '0;
            r_bt_seen        <= '0;
            r_wifi_seen      <= '0;
            r_drift          <= '0;
            r_trim_written   <= '0;
            r_power          <= 1'b0;
        end else if (s3_go) begin
            r_mode           <= n_mode;
            r_committed_last <= n_committed_last;
            r_trim_written   <= n_trim_written;
            r_power          <= n_power;
            case (r3_op)
                OP_USB: begin
                    r_usb_seen <= r3_now;
                    r_drift    <= n_drift;
                end
                OP_BT:   r_bt_seen   <= r3_now;
                OP_WIFI: r_wifi_seen <= r3_now;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_mode      <= n_mode;
            r_out_committed <= n_committed;
            r_out_mute      <= n_mute;
            r_out_stream    <= n_stream;
            r_out_pll_write <= n_pll_write;
            r_out_pll_n     <= n_pll_n;
            r_out_power     <= n_power;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mode           = r_out_mode;
    assign o_mode_committed = r_out_committed;
    assign o_mute_action    = r_out_mute;
    assign o_stream_action  = r_out_stream;
    assign o_pll_write      = r_out_pll_write;
    assign o_pll_n          = r_out_pll_n;
    assign o_power_enable   = r_out_power;

endmodule
